[hw/rtl/mexp_pkg.sv]
`timescale 1ns / 1ps

package mexp_pkg;

    localparam int unsigned WordW  = 64;
    localparam int unsigned StepW  = 6;

    // operand routing for one shift-and-add step of the modular multiplier
    typedef enum logic [1:0] {
        OP_REDUCE  = 2'd0,
        OP_MUL_ACC = 2'd1,
        OP_SQUARE  = 2'd2
    } op_t;

    typedef struct packed {
        logic load;
        logic step;
        op_t  op;
        logic start_mul;
        logic commit_base;
        logic commit_acc;
        logic shift_exp;
        logic emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic exp_zero;
        logic exp_lsb;
    } dp_status_t;

endpackage

[hw/rtl/mexp_datapath.sv]
`timescale 1ns / 1ps

module mexp_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [mexp_pkg::WordW-1:0]      cfg_modulus,
    input  logic [mexp_pkg::WordW-1:0]      in_base,
    input  logic [mexp_pkg::WordW-1:0]      in_exponent,
    input  mexp_pkg::ctl_cmd_t              cmd,
    output mexp_pkg::dp_status_t            status,
    output logic [mexp_pkg::WordW-1:0]      result
);

    localparam int unsigned W = mexp_pkg::WordW;

    logic [W-1:0]   mod_reg;
    logic [W-1:0]   base_reg;
    logic [W-1:0]   acc_reg;
    logic [W-1:0]   exp_reg;
    logic [W-1:0]   mb_reg;
    logic [W-1:0]   r_reg;
    logic [W-1:0]   out_reg;

    logic [W-1:0]   operand;
    logic [W-1:0]   addend;
    logic [W+1:0]   t_sum;
    logic [W+1:0]   m1;
    logic [W+1:0]   m2;
    logic [W-1:0]   r_next;

    // modulus register, the one configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg <= W'(2);
        end else if (cfg_we) begin
            mod_reg <= cfg_modulus;
        end
    end

    always_comb begin
        operand = base_reg;
        unique case (cmd.op)
            mexp_pkg::OP_MUL_ACC: operand = acc_reg;
            mexp_pkg::OP_SQUARE:  operand = base_reg;
            default:              operand = base_reg;
        endcase
    end

    // reduction feeds the base in one bit at a time, multiplies add the operand
    always_comb begin
        if (cmd.op == mexp_pkg::OP_REDUCE) begin
            addend = {{(W-1){1'b0}}, mb_reg[W-1]};
        end else begin
            addend = mb_reg[W-1] ? operand : '0;
        end
    end

    // t = 2r + addend stays below 3m, so at most two moduli come off
    always_comb begin
        m1    = {2'b00, mod_reg};
        m2    = {1'b0, mod_reg, 1'b0};
        t_sum = {1'b0, r_reg, 1'b0} + {2'b00, addend};
        if (t_sum >= m2) begin
            r_next = W'(t_sum - m2);
        end else if (t_sum >= m1) begin
            r_next = W'(t_sum - m1);
        end else begin
            r_next = W'(t_sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mb_reg  <= in_base;
            r_reg   <= '0;
            exp_reg <= in_exponent;
            acc_reg <= W'(1);
        end
        if (cmd.step) begin
            r_reg  <= r_next;
            mb_reg <= {mb_reg[W-2:0], 1'b0};
        end
        if (cmd.start_mul) begin
            r_reg  <= '0;
            mb_reg <= base_reg;
        end
        if (cmd.commit_base) begin
            base_reg <= r_next;
        end
        if (cmd.commit_acc) begin
            acc_reg <= r_next;
        end
        if (cmd.shift_exp) begin
            exp_reg <= {1'b0, exp_reg[W-1:1]};
        end
        if (cmd.emit) begin
            // a modulus below two gives zero throughout
            out_reg <= (mod_reg < W'(2)) ? '0 : acc_reg;
        end
    end

    assign status.exp_zero = (exp_reg == '0);
    assign status.exp_lsb  = exp_reg[0];
    assign result          = out_reg;

endmodule

[hw/rtl/mexp_ctrl.sv]
`timescale 1ns / 1ps

module mexp_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    input  mexp_pkg::dp_status_t    status,
    output mexp_pkg::ctl_cmd_t      cmd
);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_REDUCE  = 6'b000010,
        ST_CHECK   = 6'b000100,
        ST_MUL_ACC = 6'b001000,
        ST_SQUARE  = 6'b010000,
        ST_FINISH  = 6'b100000
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [mexp_pkg::StepW-1:0]     step_cnt_reg;
    logic [mexp_pkg::StepW-1:0]     step_cnt_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           last_step;

    assign last_step = &step_cnt_reg;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;

    always_comb begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        cmd           = '0;
        cmd.op        = mexp_pkg::OP_REDUCE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load      = 1'b1;
                    step_cnt_next = '0;
                    state_next    = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                cmd.step      = 1'b1;
                cmd.op        = mexp_pkg::OP_REDUCE;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (last_step) begin
                    cmd.commit_base = 1'b1;
                    state_next      = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.exp_zero) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.start_mul = 1'b1;
                    step_cnt_next = '0;
                    state_next    = status.exp_lsb ? ST_MUL_ACC : ST_SQUARE;
                end
            end
            ST_MUL_ACC: begin
                cmd.step      = 1'b1;
                cmd.op        = mexp_pkg::OP_MUL_ACC;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (last_step) begin
                    // counter wraps to zero for the squaring that follows
                    cmd.commit_acc = 1'b1;
                    cmd.start_mul  = 1'b1;
                    state_next     = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                cmd.step      = 1'b1;
                cmd.op        = mexp_pkg::OP_SQUARE;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (last_step) begin
                    cmd.commit_base = 1'b1;
                    cmd.shift_exp   = 1'b1;
                    state_next      = ST_CHECK;
                end
            end
            ST_FINISH: begin
                // wait until the output register is free
                if (!out_valid_reg || m_tready) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_cnt_reg  <= step_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!out_valid_reg || m_tready))
        else $error("result overwritten while still pending");

    a_mul_starts_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK && !status.exp_zero) |=> (step_cnt_reg == '0))
        else $error("multiply started with a stale step count");

    a_fell_on_take: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(out_valid_reg) |-> $past(m_tready))
        else $error("result dropped without being taken");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while another is in progress");

endmodule

[hw/rtl/modular_exponentiation_core.sv]
`timescale 1ns / 1ps
// modular exponentiation core: base^exponent mod modulus, right-to-left
// square-and-multiply on a shift-and-add modular multiplier
// s_ channel: one request per item, base_value in tdata[63:0], exponent in
// tdata[127:64]; s_tready is high only while the core is idle
// m_ channel: one result per request, power_result in tdata[63:0]
// cfg channel: writes the 64-bit modulus, always ready; write only when idle
// operation: the multiplier does one bit of one operand per cycle; the base is
// reduced first, then every exponent bit up to the highest set one is handled
// by a check and a squaring, plus a multiply into the accumulator when that
// bit is set; one request is worked on at a time
// a finished result sits in an output register, so a new request is taken
// while the receiver stalls; the core only waits if a second result is
// ready before the first has been taken
// reset: aresetn low at a clock edge empties the core and sets modulus to 2
// a modulus of 0 or 1 gives a result of 0
module modular_exponentiation_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [127:0]    s_tdata,    // base_value, exponent
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [63:0]     m_tdata,    // power_result
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [63:0]     cfg_data    // modulus
);

    mexp_pkg::ctl_cmd_t     cmd;
    mexp_pkg::dp_status_t   status;

    assign cfg_ready = 1'b1;

    mexp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mexp_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_modulus (cfg_data),
        .in_base     (s_tdata[63:0]),
        .in_exponent (s_tdata[127:64]),
        .cmd         (cmd),
        .status      (status),
        .result      (m_tdata)
    );

endmodule

[tb/sv/modular_exponentiation_core_tb.sv]
`timescale 1ns / 1ps

module modular_exponentiation_core_tb;

    localparam int unsigned WordW         = mexp_pkg::WordW;
    localparam int          DirRows       = 24;
    localparam int          RandPhases    = 8;
    localparam int          PhaseItems    = 85;
    localparam int          RxHoldCycles  = 3000;
    localparam int          StallLimit    = 60000;
    localparam int          TailCycles    = 200;
    localparam logic [WordW-1:0] Ones     = {WordW{1'b1}};
    localparam logic [WordW-1:0] TopBit   = {1'b1, {(WordW-1){1'b0}}};
    localparam logic [WordW-1:0] Prime64  = 64'hFFFF_FFFF_FFFF_FFC5;

    typedef struct packed {
        logic             set_mod;
        logic [WordW-1:0] mod_val;
        logic [WordW-1:0] base;
        logic [WordW-1:0] expo;
        logic             typed;
        logic [WordW-1:0] want;
    } dir_row_t;

    typedef struct packed {
        logic [WordW-1:0] base;
        logic [WordW-1:0] expo;
        logic [WordW-1:0] modv;
        logic [WordW-1:0] want;
    } power_exp_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid;
    logic               s_tready;
    logic [2*WordW-1:0] s_tdata;    // base_value, exponent
    logic               m_tvalid;
    logic               m_tready;
    logic [WordW-1:0]   m_tdata;    // power_result
    logic               cfg_valid;
    logic               cfg_ready;
    logic [WordW-1:0]   cfg_data;   // modulus

    dir_row_t           dir_table [DirRows];
    power_exp_t         power_q [$];
    logic [WordW-1:0]   cur_modulus = 64'd2;
    int                 items_sent = 0;
    int                 results_seen = 0;
    int                 mismatches = 0;
    int                 unexpected = 0;
    int                 mod_writes = 0;
    int                 wide_exps = 0;
    int                 idle_cycles = 0;
    logic               rx_held = 1'b0;

    modular_exponentiation_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic [WordW-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // right-to-left square-and-multiply with exact 128-bit products
    function automatic logic [WordW-1:0] predict_power(input logic [WordW-1:0] m,
                                                       input logic [WordW-1:0] b,
                                                       input logic [WordW-1:0] e);
        logic [WordW-1:0]   acc;
        logic [WordW-1:0]   sq;
        logic [2*WordW-1:0] prod;
        int                 i;
        if (m < 2) begin
            return '0;
        end
        acc = 64'd1;
        sq  = b % m;
        for (i = 0; i < WordW; i++) begin
            if (e[i]) begin
                prod = acc * sq;
                acc  = WordW'(prod % m);
            end
            prod = sq * sq;
            sq   = WordW'(prod % m);
        end
        return acc;
    endfunction

    task automatic offer_power_request(input logic [WordW-1:0] b, input logic [WordW-1:0] e,
                                       input logic use_typed, input logic [WordW-1:0] typed_val);
        power_exp_t ent;
        logic       quiet;
        quiet = (items_sent >= 450 && items_sent < 560);
        while (!quiet && $urandom_range(0, 99) < 13) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {e, b};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ent.base = b;
        ent.expo = e;
        ent.modv = cur_modulus;
        ent.want = use_typed ? typed_val : predict_power(cur_modulus, b, e);
        power_q.push_back(ent);
        items_sent++;
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (power_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_modulus(input logic [WordW-1:0] value);
        wait_results_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid   <= 1'b0;
        cur_modulus  = value;
        mod_writes++;
    endtask

    // optional modulus write, base, exponent and, where obvious, the answer; the modulus is 2 out of reset
    initial begin
        dir_table[0]  = '{1'b0, 64'd0,   64'd0,       64'd0,       1'b1, 64'd1};
        dir_table[1]  = '{1'b0, 64'd0,   64'd3,       64'd5,       1'b1, 64'd1};
        dir_table[2]  = '{1'b0, 64'd0,   Ones,        Ones,        1'b1, 64'd1};
        dir_table[3]  = '{1'b0, 64'd0,   64'd2,       64'd1,       1'b1, 64'd0};
        dir_table[4]  = '{1'b1, Ones,    64'd0,       64'd0,       1'b1, 64'd1};
        dir_table[5]  = '{1'b0, 64'd0,   64'd0,       64'd1,       1'b1, 64'd0};
        dir_table[6]  = '{1'b0, 64'd0,   Ones,        64'd1,       1'b1, 64'd0};
        dir_table[7]  = '{1'b0, 64'd0,   Ones - 1,    64'd2,       1'b1, 64'd1};
        dir_table[8]  = '{1'b0, 64'd0,   Ones - 1,    Ones,        1'b1, Ones - 1};
        dir_table[9]  = '{1'b0, 64'd0,   64'd1,       Ones,        1'b1, 64'd1};
        dir_table[10] = '{1'b0, 64'd0,   64'h0123_4567_89AB_CDEF, Ones, 1'b0, 64'd0};
        // modulus below two gives zero whatever the request
        dir_table[11] = '{1'b1, 64'd0,   64'hDEAD_BEEF, 64'd0,     1'b1, 64'd0};
        dir_table[12] = '{1'b0, 64'd0,   Ones,        Ones,        1'b1, 64'd0};
        dir_table[13] = '{1'b1, 64'd1,   64'd5,       64'd0,       1'b1, 64'd0};
        dir_table[14] = '{1'b0, 64'd0,   64'd7,       64'd3,       1'b1, 64'd0};
        dir_table[15] = '{1'b1, Prime64, 64'd2,       64'd64,      1'b0, 64'd0};
        dir_table[16] = '{1'b0, 64'd0,   64'd3,       Prime64 - 1, 1'b0, 64'd0};
        dir_table[17] = '{1'b0, 64'd0,   Ones,        TopBit,      1'b0, 64'd0};
        dir_table[18] = '{1'b1, 64'd1000, 64'd2,      64'd10,      1'b1, 64'd24};
        dir_table[19] = '{1'b0, 64'd0,   64'd1999,    64'd1,       1'b1, 64'd999};
        dir_table[20] = '{1'b0, 64'd0,   64'd0,       64'd0,       1'b1, 64'd1};
        dir_table[21] = '{1'b1, TopBit,  64'd3,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'd0};
        dir_table[22] = '{1'b0, 64'd0,   Ones,        64'd2,       1'b1, 64'd1};
        dir_table[23] = '{1'b0, 64'd0,   TopBit,      64'd1,       1'b1, 64'd0};
    end

    // receiver: random back-pressure, one long hold-off, then a quiet stretch
    initial begin
        m_tready = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!rx_held && results_seen >= 150) begin
                rx_held = 1'b1;
                m_tready <= 1'b0;
                repeat (RxHoldCycles) @(posedge aclk);
            end else begin
                m_tready <= (results_seen >= 440 && results_seen < 560) ||
                            ($urandom_range(0, 99) >= 13);
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        power_exp_t exp_ent;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (power_q.size() == 0) begin
                unexpected++;
                $display("result %h with no request outstanding", m_tdata);
            end else begin
                exp_ent = power_q.pop_front();
                if (m_tdata !== exp_ent.want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("power_result mismatch: base %h exp %h mod %h: expected %h, got %h",
                                 exp_ent.base, exp_ent.expo, exp_ent.modv, exp_ent.want, m_tdata);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= StallLimit) begin
            $display("no handshake for %0d cycles, %0d requests outstanding",
                     StallLimit, power_q.size());
            $display("[modular_exponentiation_core] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int               k;
        int               phase;
        int               r;
        int               len;
        logic [WordW-1:0] b;
        logic [WordW-1:0] e;
        logic [WordW-1:0] m;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (k = 0; k < DirRows; k++) begin
            if (dir_table[k].set_mod) begin
                write_modulus(dir_table[k].mod_val);
            end
            offer_power_request(dir_table[k].base, dir_table[k].expo,
                                dir_table[k].typed, dir_table[k].want);
        end

        for (phase = 0; phase < RandPhases; phase++) begin
            case (phase)
                0: m = Ones;
                1: m = 64'd2;
                2: m = 64'd3;
                3: m = TopBit | (rand_word() >> 1);
                4: begin
                    len = $urandom_range(2, 32);
                    m = rand_word() & ((64'd1 << len) - 1);
                    m[len-1] = 1'b1;
                end
                5: m = Prime64;
                6: m = TopBit;
                default: m = rand_word();
            endcase
            if (m < 2) begin
                m = 64'd2;
            end
            write_modulus(m);
            for (k = 0; k < PhaseItems; k++) begin
                case ($urandom_range(0, 9))
                    0: b = WordW'($urandom_range(0, 3));
                    1: b = cur_modulus - 1;
                    2: b = cur_modulus + WordW'($urandom_range(0, 2));
                    default: b = rand_word();
                endcase
                // long exponents are slow, so most are short
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    e = rand_word();
                    wide_exps++;
                end else if (r < 5) begin
                    e = Ones;
                    wide_exps++;
                end else if (r < 10) begin
                    e = WordW'($urandom_range(0, 1));
                end else begin
                    len = $urandom_range(1, 12);
                    e = rand_word() & ((64'd1 << len) - 1);
                end
                offer_power_request(b, e, 1'b0, '0);
            end
        end

        wait_results_drained();
        repeat (TailCycles) @(posedge aclk);

        $display("%0d requests (%0d from the table), %0d results, %0d modulus writes",
                 items_sent, DirRows, results_seen, mod_writes);
        $display("%0d full-width exponents, receiver held off for %0d cycles once",
                 wide_exps, RxHoldCycles);
        if (mismatches == 0 && unexpected == 0 && power_q.size() == 0) begin
            $display("[modular_exponentiation_core] OK");
        end else begin
            $display("%0d mismatches, %0d unexpected, %0d missing",
                     mismatches, unexpected, power_q.size());
            $display("[modular_exponentiation_core] ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_datapath.sv
hw/rtl/mexp_ctrl.sv
hw/rtl/modular_exponentiation_core.sv
tb/sv/modular_exponentiation_core_tb.sv
